// ===== design/chd_pkg.sv =====
package chd_pkg;

  typedef enum logic [4:0] {
    PH_SIZE  = 5'b00001,
    PH_SKIP  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  // low nibble of 'a'..'f' is 1..6, digit value is that plus 9
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;
  localparam int         HEX_BITS = 4;
  localparam int         LEN_W    = 16;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             is_end;
    logic [LEN_W-1:0] body_length;
    logic             run_last;
  } beat_t;

  typedef struct packed {
    logic  v0;
    logic  v1;
    beat_t b0;
    beat_t b1;
  } push_t;

endpackage

// ===== design/chd_core.sv =====
module chd_core #(
  parameter int SIZE_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_eob,
  input  logic           room,
  output chd_pkg::push_t push
);

  logic                    v_r, v_nxt;
  logic [7:0]              byte_r;
  logic                    eob_r;
  logic                    go;
  logic                    in_acc;

  chd_pkg::phase_t         phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]    chunk_r, chunk_nxt;
  logic                    saw_r, saw_nxt;
  logic [SIZE_BITS-1:0]    left_r, left_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;

  logic [7:0]              low;
  logic                    is_dec, is_alpha, is_digit;
  logic [3:0]              dval;
  logic [SIZE_BITS-1:0]    acc;
  logic                    ld_end;
  chd_pkg::phase_t         ld_phase;

  chd_pkg::phase_t         sb_phase;
  logic [SIZE_BITS-1:0]    sb_chunk;
  logic                    sb_saw;
  logic [SIZE_BITS-1:0]    sb_left;

  logic [COUNT_BITS+chd_pkg::LEN_W-1:0] len_ext;
  chd_pkg::beat_t          data_beat, end_beat;

  assign go       = v_r && room;
  assign in_stall = v_r && !go;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    v_nxt = v_r;
    if (in_acc) begin
      v_nxt = 1'b1;
    end else if (go) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_byte;
      eob_r  <= in_eob;
    end
  end

  // hex digit decode and saturating accumulate
  assign low      = byte_r | chd_pkg::CASE_BIT;
  assign is_dec   = (byte_r >= chd_pkg::CH_ZERO) && (byte_r <= chd_pkg::CH_NINE);
  assign is_alpha = (low >= chd_pkg::CH_LA) && (low <= chd_pkg::CH_LF_HEX);
  assign is_digit = is_dec || is_alpha;
  assign dval     = is_dec ? byte_r[3:0] : (low[3:0] + chd_pkg::HEX_ALPHA_OFS);
  assign acc      = (|chunk_r[SIZE_BITS-1 -: chd_pkg::HEX_BITS]) ? '1
                    : {chunk_r[SIZE_BITS-chd_pkg::HEX_BITS-1:0], dval};

  assign ld_end   = !saw_r || (chunk_r == '0);
  assign ld_phase = ld_end ? chd_pkg::PH_DONE : chd_pkg::PH_DATA;

  // outcome of one size-line byte
  always_comb begin
    sb_phase = chd_pkg::PH_SKIP;
    sb_chunk = chunk_r;
    sb_saw   = saw_r;
    sb_left  = left_r;
    if (is_digit) begin
      sb_phase = chd_pkg::PH_SIZE;
      sb_chunk = acc;
      sb_saw   = 1'b1;
    end else if (byte_r == chd_pkg::CH_LF) begin
      sb_phase = ld_phase;
      sb_chunk = '0;
      sb_saw   = 1'b0;
      sb_left  = chunk_r;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    chunk_nxt = chunk_r;
    saw_nxt   = saw_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    unique case (phase_r)
      chd_pkg::PH_SIZE: begin
        phase_nxt = sb_phase;
        chunk_nxt = sb_chunk;
        saw_nxt   = sb_saw;
        left_nxt  = sb_left;
      end
      chd_pkg::PH_SKIP: begin
        if (byte_r == chd_pkg::CH_LF) begin
          phase_nxt = ld_phase;
          chunk_nxt = '0;
          saw_nxt   = 1'b0;
          left_nxt  = chunk_r;
        end
      end
      chd_pkg::PH_DATA: begin
        if (!(&count_r)) begin
          count_nxt = count_r + 1'b1;
        end
        if (left_r != '0) begin
          left_nxt = left_r - 1'b1;
        end
        if (left_r <= SIZE_BITS'(1)) begin
          phase_nxt = chd_pkg::PH_TRAIL;
        end
      end
      chd_pkg::PH_TRAIL: begin
        if ((byte_r != chd_pkg::CH_CR) && (byte_r != chd_pkg::CH_LF)) begin
          phase_nxt = sb_phase;
          chunk_nxt = sb_chunk;
          saw_nxt   = sb_saw;
          left_nxt  = sb_left;
        end
      end
      chd_pkg::PH_DONE: begin
      end
      default: begin
        phase_nxt = chd_pkg::PH_SIZE;
      end
    endcase
    if (eob_r) begin
      phase_nxt = chd_pkg::PH_SIZE;
      chunk_nxt = '0;
      saw_nxt   = 1'b0;
      left_nxt  = '0;
      count_nxt = '0;
    end
  end

  assign len_ext = {{chd_pkg::LEN_W{1'b0}}, count_nxt};

  always_comb begin
    data_beat.data_byte   = byte_r;
    data_beat.is_end      = 1'b0;
    data_beat.body_length = '0;
    data_beat.run_last    = !eob_r;
    end_beat.data_byte    = '0;
    end_beat.is_end       = 1'b1;
    end_beat.body_length  = '0;
    end_beat.run_last     = 1'b1;
    // provisional length from count_nxt, which end of buffer clears; push overrides it with mark_len
    if (phase_r == chd_pkg::PH_DATA) begin
      if (!(&count_r)) begin
        end_beat.body_length = len_ext[chd_pkg::LEN_W-1:0] + 1'b1;
      end else begin
        end_beat.body_length = len_ext[chd_pkg::LEN_W-1:0];
      end
    end
  end

  // count_nxt is cleared on end of buffer, so rebuild the marker count from count_r
  logic [COUNT_BITS+chd_pkg::LEN_W-1:0] cnt_ext;
  logic [chd_pkg::LEN_W-1:0]            mark_len;
  logic [COUNT_BITS-1:0]                cnt_after;

  assign cnt_after = ((phase_r == chd_pkg::PH_DATA) && !(&count_r)) ? count_r + 1'b1
                     : count_r;
  assign cnt_ext   = {{chd_pkg::LEN_W{1'b0}}, cnt_after};
  assign mark_len  = cnt_ext[chd_pkg::LEN_W-1:0];

  always_comb begin
    push.v0 = 1'b0;
    push.v1 = 1'b0;
    push.b0 = data_beat;
    push.b1 = end_beat;
    push.b1.body_length = mark_len;
    if (go) begin
      if (phase_r == chd_pkg::PH_DATA) begin
        push.v0 = 1'b1;
        push.v1 = eob_r;
      end else if (eob_r) begin
        push.v0 = 1'b1;
        push.b0 = end_beat;
        push.b0.body_length = mark_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= 1'b0;
      phase_r <= chd_pkg::PH_SIZE;
      chunk_r <= '0;
      saw_r   <= 1'b0;
      left_r  <= '0;
      count_r <= '0;
    end else begin
      v_r <= v_nxt;
      if (go) begin
        phase_r <= phase_nxt;
        chunk_r <= chunk_nxt;
        saw_r   <= saw_nxt;
        left_r  <= left_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

// ===== design/chd_outq.sv =====
module chd_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  chd_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output chd_pkg::beat_t out_beat
);

  chd_pkg::beat_t mem_r [4];
  logic [1:0]     wr_r, wr_nxt;
  logic [1:0]     rd_r, rd_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [1:0]     npush;
  logic           pop;

  assign npush     = {1'b0, push.v0} + {1'b0, push.v1};
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  // room for two more beats regardless of what drains this cycle
  assign room      = !cnt_r[2] && !cnt_r[1];
  assign out_beat  = mem_r[rd_r];

  assign wr_nxt  = wr_r + npush;
  assign rd_nxt  = rd_r + {1'b0, pop};
  assign cnt_nxt = cnt_r + {1'b0, npush} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_r] <= push.b0;
    end
    if (push.v1) begin
      mem_r[wr_r + 2'd1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall  | byte_in, end_of_buffer
// out_     | output    | out_valid / out_stall| data_byte, is_end, body_length, run_last
//
// One byte per cycle while the output queue has room; a byte lands in the input register,
// is decoded from there and its beats are written into the output queue.
// A data byte that ends the buffer makes two beats; the 4-entry output queue
// absorbs the extra one, and input stalls only when the queue holds two or more.
// Reset is synchronous, active low, and clears the decoder state and the queue.
// out_stall backs up through the queue into in_stall with no combinational path.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_is_end,
  output logic [15:0] out_body_length,
  output logic        out_run_last
);

  chd_pkg::push_t push;
  chd_pkg::beat_t beat;
  logic           room;

  chd_core #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte_in),
    .in_eob   (in_end_of_buffer),
    .room     (room),
    .push     (push)
  );

  chd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (beat)
  );

  assign out_data_byte   = beat.data_byte;
  assign out_is_end      = beat.is_end;
  assign out_body_length = beat.body_length;
  assign out_run_last    = beat.run_last;

`ifndef SYNTHESIS
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0 && !push.b0.is_end && push.b1.is_end)
    else $error("two-beat push not data then end marker");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !room |-> !push.v0)
    else $error("push while output queue has no room");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_run_last && (out_data_byte == 8'd0))
    else $error("end marker beat malformed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam chd_pkg::beat_t NO_BEAT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_is_end;
  logic [15:0] out_body_length;
  logic        out_run_last;

  http_chunked_body_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_is_end       (out_is_end),
    .out_body_length  (out_body_length),
    .out_run_last     (out_run_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder shadow state
  chd_pkg::phase_t ph;
  logic [31:0]     size_acc;
  logic            have_digit;
  logic [31:0]     remaining;
  logic [15:0]     emitted;

  chd_pkg::beat_t  pending_beats[$];
  logic [7:0]      frame[$];
  bit              in_idle_en;
  bit              out_idle_en;
  int              fail_cnt;
  int              beats_seen;
  int              markers_seen;
  int              bytes_fed;
  int              bodies;

  function automatic void restart_body();
    ph         = chd_pkg::PH_SIZE;
    size_acc   = '0;
    have_digit = 1'b0;
    remaining  = '0;
    emitted    = '0;
  endfunction

  function automatic void end_size_line();
    if (!have_digit || size_acc == 0) begin
      ph = chd_pkg::PH_DONE;
    end else begin
      remaining = size_acc;
      ph        = chd_pkg::PH_DATA;
    end
    size_acc   = '0;
    have_digit = 1'b0;
  endfunction

  function automatic void size_char(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    logic       is_hex;
    lc     = c | chd_pkg::CASE_BIT;
    is_hex = 1'b1;
    d      = '0;
    if (c >= chd_pkg::CH_ZERO && c <= chd_pkg::CH_NINE) d = c - chd_pkg::CH_ZERO;
    else if (lc >= chd_pkg::CH_LA && lc <= chd_pkg::CH_LF_HEX)
      d = lc - chd_pkg::CH_LA + 8'd10;
    else is_hex = 1'b0;
    if (!is_hex) begin
      if (c == chd_pkg::CH_LF) end_size_line();
      else ph = chd_pkg::PH_SKIP;
    end else begin
      if (size_acc > (32'hFFFF_FFFF - 32'(d)) / 16) size_acc = '1;
      else size_acc = size_acc * 16 + 32'(d);
      have_digit = 1'b1;
      ph         = chd_pkg::PH_SIZE;
    end
  endfunction

  function automatic int decode_byte(input logic [7:0] c, input logic eob,
                                     output chd_pkg::beat_t r0,
                                     output chd_pkg::beat_t r1);
    chd_pkg::beat_t rr[2];
    int             n;
    n     = 0;
    rr[0] = NO_BEAT;
    rr[1] = NO_BEAT;
    case (ph)
      chd_pkg::PH_SIZE:  size_char(c);
      chd_pkg::PH_SKIP:  if (c == chd_pkg::CH_LF) end_size_line();
      chd_pkg::PH_DATA: begin
        rr[0] = '{data_byte: c, is_end: 1'b0, body_length: '0, run_last: ~eob};
        n = 1;
        if (emitted != '1) emitted++;
        if (remaining != 0) remaining--;
        if (remaining == 0) ph = chd_pkg::PH_TRAIL;
      end
      chd_pkg::PH_TRAIL:
        if (c != chd_pkg::CH_CR && c != chd_pkg::CH_LF) size_char(c);
      default: ;
    endcase
    if (eob) begin
      rr[n] = '{data_byte: 8'h00, is_end: 1'b1, body_length: emitted, run_last: 1'b1};
      n++;
      restart_body();
    end
    r0 = rr[0];
    r1 = rr[1];
    return n;
  endfunction

  function automatic chd_pkg::beat_t end_mark(input logic [15:0] len);
    return '{data_byte: 8'h00, is_end: 1'b1, body_length: len, run_last: 1'b1};
  endfunction

  function automatic chd_pkg::beat_t data_beat(input logic [7:0] c, input logic last);
    return '{data_byte: c, is_end: 1'b0, body_length: '0, run_last: last};
  endfunction

  function automatic void log_fail(input bit orphan, input chd_pkg::beat_t want,
                                   input chd_pkg::beat_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      if (orphan)
        $display("%0t: beat %0d with nothing pending: data=%02h end=%0b len=%0d last=%0b",
                 $time, beats_seen, got.data_byte, got.is_end, got.body_length,
                 got.run_last);
      else
        $display({"%0t: beat %0d expected data=%02h end=%0b len=%0d last=%0b,",
                  " got data=%02h end=%0b len=%0d last=%0b"},
                 $time, beats_seen, want.data_byte, want.is_end, want.body_length,
                 want.run_last, got.data_byte, got.is_end, got.body_length,
                 got.run_last);
    end
  endfunction

  always @(posedge clk) begin
    chd_pkg::beat_t got;
    chd_pkg::beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{data_byte: out_data_byte, is_end: out_is_end,
              body_length: out_body_length, run_last: out_run_last};
      beats_seen++;
      if (got.is_end === 1'b1) markers_seen++;
      if (pending_beats.size() == 0) begin
        log_fail(1'b1, NO_BEAT, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.data_byte !== want.data_byte || got.is_end !== want.is_end ||
            got.body_length !== want.body_length || got.run_last !== want.run_last)
          log_fail(1'b0, want, got);
      end
    end
  end

  // receiver backpressure in bursts
  initial begin : out_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if (out_idle_en && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 7);
      out_stall <= (hold > 0);
    end
  end

  // typed_n < 0: take the prediction; otherwise the typed beats stand
  task automatic feed_byte(input logic [7:0] c, input logic eob, input int typed_n,
                           input chd_pkg::beat_t t0, input chd_pkg::beat_t t1);
    chd_pkg::beat_t p0;
    chd_pkg::beat_t p1;
    int             n;
    if (in_idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte_in       <= c;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (in_stall);
    n = decode_byte(c, eob, p0, p1);
    if (typed_n >= 0) begin
      n  = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) pending_beats.push_back(p0);
    if (n > 1) pending_beats.push_back(p1);
    bytes_fed++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < 10) ch = chd_pkg::CH_ZERO + 8'(d);
    else if ($urandom_range(0, 1) == 1)
      ch = (chd_pkg::CH_LA & ~chd_pkg::CASE_BIT) + 8'(d) - 8'd10;
    else ch = chd_pkg::CH_LA + 8'(d) - 8'd10;
    return ch;
  endfunction

  function automatic void put_size(input logic [31:0] v, input int zeros);
    bit started;
    started = 1'b0;
    for (int k = 0; k < zeros; k++) frame.push_back(chd_pkg::CH_ZERO);
    for (int k = 7; k >= 0; k--) begin
      if (v[k*4 +: 4] != 0 || started || k == 0) begin
        started = 1'b1;
        frame.push_back(hex_char(v[k*4 +: 4]));
      end
    end
  endfunction

  function automatic void put_eol();
    if ($urandom_range(0, 3) != 0) frame.push_back(chd_pkg::CH_CR);
    frame.push_back(chd_pkg::CH_LF);
  endfunction

  function automatic void build_body();
    int kind;
    int sz;
    int cut;
    logic [7:0] junk;
    frame.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise weighted toward framing characters
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 3))
          0: frame.push_back(8'($urandom_range(0, 255)));
          1: frame.push_back(hex_char(4'($urandom_range(0, 15))));
          2: frame.push_back(chd_pkg::CH_CR);
          default: frame.push_back(chd_pkg::CH_LF);
        endcase
      end
    end else if (kind < 16) begin
      // oversized chunk: size register pins at all ones, body always cut short
      frame.push_back(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(8, 11)) frame.push_back(hex_char(4'($urandom_range(0, 15))));
      put_eol();
      repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        put_size(32'(sz), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
        if ($urandom_range(0, 3) == 0) begin
          frame.push_back(8'h3B);
          repeat ($urandom_range(0, 4)) begin
            junk = 8'($urandom_range(0, 255));
            frame.push_back(junk == chd_pkg::CH_LF ? 8'h65 : junk);
          end
        end
        put_eol();
        repeat (sz) frame.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: begin
            frame.push_back(chd_pkg::CH_CR);
            frame.push_back(chd_pkg::CH_LF);
          end
          1: frame.push_back(chd_pkg::CH_LF);
          2: begin
            frame.push_back(chd_pkg::CH_CR);
            frame.push_back(chd_pkg::CH_LF);
            frame.push_back(chd_pkg::CH_CR);
          end
          default: ;
        endcase
      end
      case ($urandom_range(0, 19))
        0, 1, 2: frame.push_back(chd_pkg::CH_LF);
        3, 4, 5: begin put_size('0, 1); put_eol(); end
        default: put_size('0, 0);
      endcase
      put_eol();
      repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endfunction

  task automatic send_frame();
    for (int k = 0; k < frame.size(); k++)
      feed_byte(frame[k], k == frame.size() - 1, -1, NO_BEAT, NO_BEAT);
    bodies++;
  endtask

  typedef struct {
    logic [7:0]     c;
    logic           eob;
    int             n;
    chd_pkg::beat_t r0;
    chd_pkg::beat_t r1;
  } row_t;

  initial begin : stimulus
    row_t dir_rows[23];
    int   rand_items;

    restart_body();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    dir_rows = '{
      // end of buffer straight after reset
      '{8'h7A, 1'b1,  1, end_mark(16'd0), NO_BEAT},
      // two-byte chunk with byte extremes, then a one-byte chunk with an extension, then a zero chunk
      '{8'h32, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0D, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0A, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'hFF, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0D, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h31, 1'b0, -1, NO_BEAT, NO_BEAT},   // trailer byte opens next size line
      '{8'h3B, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h78, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0A, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h51, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h30, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0D, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0A, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h6A, 1'b0, -1, NO_BEAT, NO_BEAT},   // dropped after zero chunk
      '{8'h6B, 1'b1,  1, end_mark(16'd3), NO_BEAT},
      // size line without digits ends the body
      '{8'h0A, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h78, 1'b1,  1, end_mark(16'd0), NO_BEAT},
      // buffer ends on a data byte
      '{8'h31, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h0A, 1'b0, -1, NO_BEAT, NO_BEAT},
      '{8'h44, 1'b1,  2, data_beat(8'h44, 1'b0), end_mark(16'd1)},
      // buffer ends inside a size line
      '{8'h46, 1'b1,  1, end_mark(16'd0), NO_BEAT}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      feed_byte(dir_rows[i].c, dir_rows[i].eob, dir_rows[i].n, dir_rows[i].r0,
                dir_rows[i].r1);

    rand_items = 0;
    while (rand_items < 1530) begin
      if (rand_items > 1330) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end else begin
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
      end
      build_body();
      rand_items += frame.size();
      send_frame();
    end
    in_valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("fed %0d bytes in %0d bodies; checked %0d beats, %0d of them end markers",
             bytes_fed, bodies + 5, beats_seen, markers_seen);
    $display("covered hex case mix, extensions, truncation, size saturation; %0d bad beats",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
